// File: rtl/ipdq_pkg.sv
// Shared types and constants for the IPv4 dotted-quad parser.
package ipdq_pkg;

   localparam int POS_W = 5;
   localparam int ACC_W = 17;
   localparam int SUM_W = 21;

   localparam int MAX_COLON_POS = 21;

   localparam logic [POS_W-1:0] POS_SAT = 5'd31;
   localparam logic [ACC_W-1:0] ACC_SAT = 17'd65536;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   // Character held in the input register, with its valid bit.
   typedef struct packed {
      logic       vld;
      logic [7:0] char_code;
   } stage_type;

   typedef struct packed {
      logic        valid_res;
      logic [7:0]  octet_a;
      logic [7:0]  octet_b;
      logic [7:0]  octet_c;
      logic [7:0]  octet_d;
      logic [15:0] port_number;
      logic        has_port;
   } result_type;

endpackage

// File: rtl/ipdq_inreg.sv
// Input register stage of the IPv4 dotted-quad parser.
module ipdq_inreg import ipdq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_char_code,
   output logic       req_stall,
   input  logic       hold,
   output stage_type  stage
);

   logic       vld_ff;
   logic       vld_in;
   logic [7:0] char_ff;
   logic [7:0] char_in;

   // The register refills whenever its item moves on to the parsing stage.
   assign req_stall = vld_ff & hold;

   always_comb begin
      vld_in  = vld_ff;
      char_in = char_ff;
      if (!req_stall) begin
         vld_in = req_valid;
         if (req_valid) begin
            char_in = req_char_code;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      char_ff <= char_in;
   end

   assign stage.vld       = vld_ff;
   assign stage.char_code = char_ff;

endmodule

// File: rtl/ipdq_engine.sv
// Parsing state and per-character update logic of the IPv4 dotted-quad parser.
module ipdq_engine import ipdq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  stage_type  stage,
   input  logic       load_ok,
   output logic       hold,
   output logic       res_load,
   output result_type res
);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [1:0]       dots_ff, dots_in;
   logic             colon_ff, colon_in;
   logic             err_ff, err_in;
   logic             dac_ff, dac_in;
   logic [ACC_W-1:0] acc_ff, acc_in;
   logic [7:0]       oct_ff [4];
   logic [7:0]       oct_in [4];

   logic             is_nul;
   logic             is_digit;
   logic             step;
   logic             acc_small;
   logic             ok;
   logic [3:0]       digit;
   logic [SUM_W-1:0] sum;

   assign is_nul   = (stage.char_code == CHAR_NUL);
   assign is_digit = (stage.char_code >= CHAR_ZERO) && (stage.char_code <= CHAR_NINE);
   assign digit    = 4'(stage.char_code - CHAR_ZERO);

   // A terminating character waits while the result register is still full.
   assign hold     = is_nul & ~load_ok;
   assign step     = stage.vld & ~hold;
   assign res_load = step & is_nul;

   assign acc_small = (acc_ff[ACC_W-1:8] == '0);
   assign sum = (SUM_W'(acc_ff) << 3) + (SUM_W'(acc_ff) << 1) + SUM_W'(digit);

   always_comb begin
      pos_in   = pos_ff;
      dots_in  = dots_ff;
      colon_in = colon_ff;
      err_in   = err_ff;
      dac_in   = dac_ff;
      acc_in   = acc_ff;
      oct_in   = oct_ff;

      ok = ~err_ff && (dots_ff == 2'd3);
      if (ok && !colon_ff && !acc_small) begin
         ok = 1'b0;
      end
      if (ok && colon_ff && (!dac_ff || acc_ff == '0 || acc_ff[ACC_W-1])) begin
         ok = 1'b0;
      end

      res.valid_res   = ok;
      res.octet_a     = ok ? oct_ff[0] : 8'd0;
      res.octet_b     = ok ? oct_ff[1] : 8'd0;
      res.octet_c     = ok ? oct_ff[2] : 8'd0;
      res.octet_d     = ok ? (colon_ff ? oct_ff[3] : acc_ff[7:0]) : 8'd0;
      res.port_number = (ok && colon_ff) ? acc_ff[15:0] : 16'd0;
      res.has_port    = ok & colon_ff;

      if (step) begin
         if (is_nul) begin
            pos_in   = '0;
            dots_in  = '0;
            colon_in = 1'b0;
            err_in   = 1'b0;
            dac_in   = 1'b0;
            acc_in   = '0;
            for (int i = 0; i < 4; i++) begin
               oct_in[i] = 8'd0;
            end
         end else begin
            if (pos_ff != POS_SAT) begin
               pos_in = pos_ff + 1'b1;
            end
            if (!err_ff) begin
               if (is_digit) begin
                  acc_in = (sum > SUM_W'(ACC_SAT)) ? ACC_SAT : sum[ACC_W-1:0];
                  if (colon_ff) begin
                     dac_in = 1'b1;
                  end
               end else if (stage.char_code == CHAR_DOT) begin
                  if (dots_ff == 2'd3 || colon_ff) begin
                     err_in = 1'b1;
                  end else begin
                     if (acc_small) begin
                        oct_in[dots_ff] = acc_ff[7:0];
                     end else begin
                        err_in = 1'b1;
                     end
                     acc_in  = '0;
                     dots_in = dots_ff + 1'b1;
                  end
               end else if (stage.char_code == CHAR_COLON) begin
                  if (colon_ff || dots_ff != 2'd3 || pos_ff > POS_W'(MAX_COLON_POS)) begin
                     err_in = 1'b1;
                  end else begin
                     if (acc_small) begin
                        oct_in[3] = acc_ff[7:0];
                     end else begin
                        err_in = 1'b1;
                     end
                     acc_in   = '0;
                     colon_in = 1'b1;
                  end
               end else begin
                  err_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         dots_ff  <= '0;
         colon_ff <= 1'b0;
         err_ff   <= 1'b0;
         dac_ff   <= 1'b0;
         acc_ff   <= '0;
         for (int i = 0; i < 4; i++) begin
            oct_ff[i] <= 8'd0;
         end
      end else begin
         pos_ff   <= pos_in;
         dots_ff  <= dots_in;
         colon_ff <= colon_in;
         err_ff   <= err_in;
         dac_ff   <= dac_in;
         acc_ff   <= acc_in;
         oct_ff   <= oct_in;
      end
   end

`ifndef SYNTHESIS
   a_colon_needs_dots: assert property (@(posedge clock) disable iff (reset)
      colon_ff |-> dots_ff == 2'd3)
      else $error("colon accepted before the third dot");

   a_port_digit_after_colon: assert property (@(posedge clock) disable iff (reset)
      dac_ff |-> colon_ff)
      else $error("port digit seen without a colon");

   a_acc_saturates: assert property (@(posedge clock) disable iff (reset)
      acc_ff <= ACC_SAT)
      else $error("digit accumulator above saturation");

   a_clear_after_nul: assert property (@(posedge clock) disable iff (reset)
      res_load |=> (dots_ff == '0 && !colon_ff && !err_ff && acc_ff == '0 && pos_ff == '0))
      else $error("parser state not cleared after an item ended");
`endif

endmodule

// File: rtl/ipdq_outreg.sv
// Result register of the IPv4 dotted-quad parser.
module ipdq_outreg import ipdq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        res_load,
   input  result_type  res,
   output logic        load_ok,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_valid_res,
   output logic [7:0]  rsp_octet_a,
   output logic [7:0]  rsp_octet_b,
   output logic [7:0]  rsp_octet_c,
   output logic [7:0]  rsp_octet_d,
   output logic [15:0] rsp_port_number,
   output logic        rsp_has_port
);

   logic       vld_ff, vld_in;
   result_type res_ff, res_in;

   // The register may take a new item when empty or when its item leaves now.
   assign load_ok = ~vld_ff | ~rsp_stall;

   always_comb begin
      vld_in = vld_ff;
      res_in = res_ff;
      if (res_load) begin
         vld_in = 1'b1;
         res_in = res;
      end else if (!rsp_stall) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      res_ff <= res_in;
   end

   assign rsp_valid       = vld_ff;
   assign rsp_valid_res   = res_ff.valid_res;
   assign rsp_octet_a     = res_ff.octet_a;
   assign rsp_octet_b     = res_ff.octet_b;
   assign rsp_octet_c     = res_ff.octet_c;
   assign rsp_octet_d     = res_ff.octet_d;
   assign rsp_port_number = res_ff.port_number;
   assign rsp_has_port    = res_ff.has_port;

endmodule

// File: rtl/ipv4_dotted_quad_parser.sv
// IPv4 dotted-quad parser: takes an address string one character per item and
// returns one result item when the terminating zero character arrives.
// Input channel (req_): one character per item; any character other than zero
// updates the parsing state and gives no result.
// Result channel (rsp_): valid flag, four octets, port number and a port flag.
// An invalid string gives a result with every other field zero.
// Path: a character is held in the input register and is parsed as it leaves
// it; the result of the zero character is then held in the result register
// and shown on rsp_.
// Throughput: one character per cycle unless a zero waits. Multiply by ten,
// range compares and octet store update finish in the single parsing stage.
// Stalls: while the result register holds an item that the receiver stalls, a
// new zero character waits in the input register and req_stall rises; other
// characters keep flowing.
// Reset clears all parsing state and empties both registers; no clearing pass.
module ipv4_dotted_quad_parser import ipdq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_code,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_valid_res,
   output logic [7:0]  rsp_octet_a,
   output logic [7:0]  rsp_octet_b,
   output logic [7:0]  rsp_octet_c,
   output logic [7:0]  rsp_octet_d,
   output logic [15:0] rsp_port_number,
   output logic        rsp_has_port
);

   stage_type  stage;
   result_type res;
   logic       hold;
   logic       res_load;
   logic       load_ok;

   ipdq_inreg u_inreg (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_char_code (req_char_code),
      .req_stall     (req_stall),
      .hold          (hold),
      .stage         (stage)
   );

   ipdq_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .stage    (stage),
      .load_ok  (load_ok),
      .hold     (hold),
      .res_load (res_load),
      .res      (res)
   );

   ipdq_outreg u_outreg (
      .clock           (clock),
      .reset           (reset),
      .res_load        (res_load),
      .res             (res),
      .load_ok         (load_ok),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_valid_res   (rsp_valid_res),
      .rsp_octet_a     (rsp_octet_a),
      .rsp_octet_b     (rsp_octet_b),
      .rsp_octet_c     (rsp_octet_c),
      .rsp_octet_d     (rsp_octet_d),
      .rsp_port_number (rsp_port_number),
      .rsp_has_port    (rsp_has_port)
   );

endmodule
